// File: rtl/core/irup_pkg.sv
// ident reply parser package: parse phase and number scan types, result entry type,
// character constants and small byte classifiers
// no dependencies
`timescale 1ns / 1ps

package irup_pkg;

   typedef enum logic [7:0] {
      PH_REMOTE  = 8'b0000_0001,
      PH_LOCAL   = 8'b0000_0010,
      PH_FIELD2  = 8'b0000_0100,
      PH_FIELD3  = 8'b0000_1000,
      PH_LEAD    = 8'b0001_0000,
      PH_NAME    = 8'b0010_0000,
      PH_DONE_OK = 8'b0100_0000,
      PH_FAIL    = 8'b1000_0000
   } phase_type;

   typedef enum logic [3:0] {
      NS_WS     = 4'b0001,
      NS_SIGN   = 4'b0010,
      NS_DIGITS = 4'b0100,
      NS_DONE   = 4'b1000
   } num_state_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] name_char;
      logic       success;
   } rsp_entry_type;

   localparam logic RK_NAME_CHAR = 1'b0;
   localparam logic RK_VERDICT   = 1'b1;

   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = 2;
   localparam int unsigned RSP_CNT_W = 3;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_BRACK  = 8'h5B;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_U      = 8'h55;

   localparam int unsigned USERID_LEN = 6;

   function automatic logic [7:0] userid_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h55; // U
         3'd1:    c = 8'h53; // S
         3'd2:    c = 8'h45; // E
         3'd3:    c = 8'h52; // R
         3'd4:    c = 8'h49; // I
         3'd5:    c = 8'h44; // D
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

endpackage

// File: rtl/core/ident_reply_username_parser_core.sv
// ident reply username parser: byte-wide scan of "remote , local : USERID : os : user",
// streams accepted username characters and one verdict per reply
// depends on irup_pkg
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | reply_byte, end_of_reply
//  rsp     | out       | rsp_valid/rsp_stall  | result_kind, name_char, success, last_of_run
//
// one byte is taken per cycle while req_stall is low; the parse state updates at the transfer and the
// zero, one or two results it yields are written into a four-entry result queue
// req_stall rises while fewer than two queue entries are free, so a byte that
// yields both a character and a verdict always finds room for both
// rsp_valid follows the registered queue count and rises in the cycle after the byte transfer
// synchronous active-high reset returns the parser to the remote port field
// and empties the queue

module ident_reply_username_parser_core #(
   parameter int unsigned MAX_NAME_CHARS  = 10,
   parameter int unsigned MAX_REPLY_BYTES = 511
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_reply_byte,
   input  logic       req_end_of_reply,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_name_char,
   output logic       rsp_success,
   output logic       rsp_last_of_run
);

   localparam int unsigned NC_W = $clog2(MAX_NAME_CHARS + 1);
   localparam int unsigned BC_W = $clog2(MAX_REPLY_BYTES + 1);

   irup_pkg::phase_type     phase_ff, phase_in, phase_proc;
   irup_pkg::num_state_type nstate_ff, nstate_in;
   logic                    remote_nz_ff, remote_nz_in;
   logic                    local_nz_ff, local_nz_in;
   logic [2:0]              match_cnt_ff, match_cnt_in;
   logic                    uid_found_ff, uid_found_in;
   logic [NC_W-1:0]         name_cnt_ff, name_cnt_in;
   logic [BC_W-1:0]         byte_cnt_ff, byte_cnt_in;

   irup_pkg::rsp_entry_type entry_ff [irup_pkg::RSP_DEPTH];
   logic [irup_pkg::RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [irup_pkg::RSP_CNT_W-1:0] count_ff, count_in;

   logic       req_xfer, rsp_xfer;
   logic       emit_char, emit_verdict, verdict_ok;
   logic [7:0] c;
   logic       num_nz;

   assign req_stall = (count_ff > irup_pkg::RSP_CNT_W'(irup_pkg::RSP_DEPTH - 2));
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign c         = req_reply_byte;

   // atoi-style scan step for whichever port field is active
   always_comb begin
      nstate_in = nstate_ff;
      num_nz    = 1'b0;
      case (nstate_ff)
         irup_pkg::NS_WS, irup_pkg::NS_SIGN, irup_pkg::NS_DIGITS: begin
            if (nstate_ff == irup_pkg::NS_WS && irup_pkg::is_ws(c)) begin
               nstate_in = irup_pkg::NS_WS;
            end else if (nstate_ff == irup_pkg::NS_WS &&
                         (c == irup_pkg::CH_PLUS || c == irup_pkg::CH_MINUS)) begin
               nstate_in = irup_pkg::NS_SIGN;
            end else if (irup_pkg::is_digit(c)) begin
               nstate_in = irup_pkg::NS_DIGITS;
               num_nz    = (c != irup_pkg::CH_ZERO);
            end else begin
               nstate_in = irup_pkg::NS_DONE;
            end
         end
         default: nstate_in = nstate_ff;
      endcase
   end

   logic                    proc_active;
   irup_pkg::num_state_type nstate_nx;
   logic                    remote_nz_nx, local_nz_nx, uid_found_nx;
   logic [2:0]              match_cnt_nx;
   logic [NC_W-1:0]         name_cnt_nx, name_cnt_inc;
   logic [BC_W-1:0]         byte_cnt_nx;

   assign name_cnt_inc = name_cnt_ff + NC_W'(1);

   always_comb begin
      phase_proc   = phase_ff;
      nstate_nx    = nstate_ff;
      remote_nz_nx = remote_nz_ff;
      local_nz_nx  = local_nz_ff;
      match_cnt_nx = match_cnt_ff;
      uid_found_nx = uid_found_ff;
      name_cnt_nx  = name_cnt_ff;
      byte_cnt_nx  = byte_cnt_ff;
      emit_char    = 1'b0;
      proc_active  = (byte_cnt_ff < BC_W'(MAX_REPLY_BYTES));

      if (proc_active) begin
         byte_cnt_nx = byte_cnt_ff + BC_W'(1);
         if (phase_ff == irup_pkg::PH_DONE_OK || phase_ff == irup_pkg::PH_FAIL) begin
            phase_proc = phase_ff;
         end else if (c == irup_pkg::CH_NUL) begin
            phase_proc = (phase_ff == irup_pkg::PH_LEAD || phase_ff == irup_pkg::PH_NAME)
                         ? irup_pkg::PH_DONE_OK : irup_pkg::PH_FAIL;
         end else begin
            case (phase_ff)
               irup_pkg::PH_REMOTE: begin
                  if (c == irup_pkg::CH_COLON) begin
                     phase_proc = irup_pkg::PH_FAIL;
                  end else if (c == irup_pkg::CH_COMMA) begin
                     if (remote_nz_ff) begin
                        phase_proc = irup_pkg::PH_LOCAL;
                        nstate_nx  = irup_pkg::NS_WS;
                     end else begin
                        phase_proc = irup_pkg::PH_FAIL;
                     end
                  end else begin
                     nstate_nx    = nstate_in;
                     remote_nz_nx = remote_nz_ff | num_nz;
                  end
               end
               irup_pkg::PH_LOCAL: begin
                  if (c == irup_pkg::CH_COLON) begin
                     phase_proc = local_nz_ff ? irup_pkg::PH_FIELD2 : irup_pkg::PH_FAIL;
                  end else begin
                     nstate_nx   = nstate_in;
                     local_nz_nx = local_nz_ff | num_nz;
                  end
               end
               irup_pkg::PH_FIELD2: begin
                  if (c == irup_pkg::CH_COLON) begin
                     phase_proc = uid_found_ff ? irup_pkg::PH_FIELD3 : irup_pkg::PH_FAIL;
                  end else if (!uid_found_ff) begin
                     if (match_cnt_ff < 3'(irup_pkg::USERID_LEN) &&
                         c == irup_pkg::userid_char(match_cnt_ff)) begin
                        if (match_cnt_ff == 3'(irup_pkg::USERID_LEN - 1)) begin
                           uid_found_nx = 1'b1;
                           match_cnt_nx = '0;
                        end else begin
                           match_cnt_nx = match_cnt_ff + 3'd1;
                        end
                     end else begin
                        match_cnt_nx = (c == irup_pkg::CH_U) ? 3'd1 : 3'd0;
                     end
                  end
               end
               irup_pkg::PH_FIELD3: begin
                  if (c == irup_pkg::CH_COLON) begin
                     phase_proc = irup_pkg::PH_LEAD;
                  end
               end
               irup_pkg::PH_LEAD, irup_pkg::PH_NAME: begin
                  // leading tilde and caret are only dropped before the name starts
                  if (!(phase_ff == irup_pkg::PH_LEAD &&
                        (c == irup_pkg::CH_TILDE || c == irup_pkg::CH_CARET))) begin
                     phase_proc = irup_pkg::PH_NAME;
                     if (c == irup_pkg::CH_AT) begin
                        phase_proc = irup_pkg::PH_DONE_OK;
                     end else if (!irup_pkg::is_ws(c) && c != irup_pkg::CH_COLON &&
                                  c != irup_pkg::CH_BRACK) begin
                        emit_char   = 1'b1;
                        name_cnt_nx = name_cnt_inc;
                        if (name_cnt_inc >= NC_W'(MAX_NAME_CHARS)) begin
                           phase_proc = irup_pkg::PH_DONE_OK;
                        end
                     end
                  end
               end
               default: phase_proc = phase_ff;
            endcase
         end
      end
   end

   assign verdict_ok   = (phase_proc == irup_pkg::PH_LEAD) ||
                         (phase_proc == irup_pkg::PH_NAME) ||
                         (phase_proc == irup_pkg::PH_DONE_OK);
   assign emit_verdict = req_end_of_reply;

   // the end of a reply puts every parse register back to its reset value
   always_comb begin
      if (req_end_of_reply) begin
         phase_in     = irup_pkg::PH_REMOTE;
         remote_nz_in = 1'b0;
         local_nz_in  = 1'b0;
         match_cnt_in = '0;
         uid_found_in = 1'b0;
         name_cnt_in  = '0;
         byte_cnt_in  = '0;
      end else begin
         phase_in     = phase_proc;
         remote_nz_in = remote_nz_nx;
         local_nz_in  = local_nz_nx;
         match_cnt_in = match_cnt_nx;
         uid_found_in = uid_found_nx;
         name_cnt_in  = name_cnt_nx;
         byte_cnt_in  = byte_cnt_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= irup_pkg::PH_REMOTE;
         nstate_ff    <= irup_pkg::NS_WS;
         remote_nz_ff <= 1'b0;
         local_nz_ff  <= 1'b0;
         match_cnt_ff <= '0;
         uid_found_ff <= 1'b0;
         name_cnt_ff  <= '0;
         byte_cnt_ff  <= '0;
      end else if (req_xfer) begin
         phase_ff     <= phase_in;
         nstate_ff    <= req_end_of_reply ? irup_pkg::NS_WS : nstate_nx;
         remote_nz_ff <= remote_nz_in;
         local_nz_ff  <= local_nz_in;
         match_cnt_ff <= match_cnt_in;
         uid_found_ff <= uid_found_in;
         name_cnt_ff  <= name_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
      end
   end

   // result queue: character first, verdict behind it
   logic                           push_char, push_verdict;
   logic [1:0]                     n_push;
   logic [irup_pkg::RSP_PTR_W-1:0] wr_ptr_in, rd_ptr_in, wr_ptr_p1;
   irup_pkg::rsp_entry_type        char_entry, verdict_entry;

   assign push_char    = req_xfer && emit_char;
   assign push_verdict = req_xfer && emit_verdict;
   assign n_push       = {1'b0, push_char} + {1'b0, push_verdict};
   assign wr_ptr_p1    = wr_ptr_ff + irup_pkg::RSP_PTR_W'(1);
   assign wr_ptr_in    = wr_ptr_ff + irup_pkg::RSP_PTR_W'(n_push);
   assign rd_ptr_in    = rd_ptr_ff + irup_pkg::RSP_PTR_W'(rsp_xfer);
   assign count_in     = count_ff + irup_pkg::RSP_CNT_W'(n_push)
                         - irup_pkg::RSP_CNT_W'(rsp_xfer);

   assign char_entry    = '{kind: irup_pkg::RK_NAME_CHAR, name_char: c, success: 1'b0};
   assign verdict_entry = '{kind: irup_pkg::RK_VERDICT, name_char: 8'h00,
                            success: verdict_ok};

   always_ff @(posedge clock) begin
      if (push_char) begin
         entry_ff[wr_ptr_ff] <= char_entry;
      end
      if (push_verdict) begin
         entry_ff[push_char ? wr_ptr_p1 : wr_ptr_ff] <= verdict_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   irup_pkg::rsp_entry_type head;
   assign head            = entry_ff[rd_ptr_ff];
   assign rsp_result_kind = head.kind;
   assign rsp_name_char   = head.name_char;
   assign rsp_success     = head.success;
   assign rsp_last_of_run = head.kind;

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= irup_pkg::RSP_CNT_W'(irup_pkg::RSP_DEPTH))
      else $error("result queue over capacity");

   // byte counter saturates at the reply limit
   a_byte_limit: assert property (@(posedge clock) disable iff (reset)
      byte_cnt_ff <= BC_W'(MAX_REPLY_BYTES))
      else $error("byte count past reply limit");

   // a final byte always leaves a verdict queued and the parser rewound
   a_end_rewind: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_end_of_reply |=>
         rsp_valid && phase_ff == irup_pkg::PH_REMOTE && byte_cnt_ff == '0)
      else $error("reply end did not rewind parser");

endmodule
